// ----- rtl/bicolor_status_led_blinker_top_macros.svh -----
// Assertion macros for the bicolor status LED blinker.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef BICOLOR_STATUS_LED_BLINKER_TOP_MACROS_SVH
`define BICOLOR_STATUS_LED_BLINKER_TOP_MACROS_SVH

// A property that must hold in the same cycle as its trigger.
`define BSLB_ASSERT_NOW(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (prop)) \
        else $error(msg);

// A property that must hold in the cycle after its trigger.
`define BSLB_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ----- rtl/bslb_pkg.sv -----
// Shared types, codes and helper functions for the bicolor status LED blinker.
// No dependencies; used by the lane, merging and top-level RTL files of the block.
package bslb_pkg;

    // Command codes carried by a request.
    localparam logic [2:0] CMD_OFF        = 3'd0;
    localparam logic [2:0] CMD_GREEN      = 3'd1;
    localparam logic [2:0] CMD_RED        = 3'd2;
    localparam logic [2:0] CMD_GREEN_SLOW = 3'd3;
    localparam logic [2:0] CMD_GREEN_FAST = 3'd4;
    localparam logic [2:0] CMD_RED_SLOW   = 3'd5;
    localparam logic [2:0] CMD_RED_FAST   = 3'd6;

    // Pin drive codes.
    localparam logic [1:0] DRIVE_RELEASED = 2'd0;
    localparam logic [1:0] DRIVE_GREEN    = 2'd1;
    localparam logic [1:0] DRIVE_RED      = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_FIRST_LED_PIN  = 2'd0;
    localparam logic [1:0] REG_SECOND_LED_PIN = 2'd1;
    localparam logic [1:0] REG_SLOW_HALF      = 2'd2;
    localparam logic [1:0] REG_FAST_HALF      = 2'd3;

    // Register reset values.
    localparam logic [7:0]  RST_FIRST_LED_PIN  = 8'd1;
    localparam logic [7:0]  RST_SECOND_LED_PIN = 8'd2;
    localparam logic [15:0] RST_SLOW_HALF      = 16'd500;
    localparam logic [15:0] RST_FAST_HALF      = 16'd100;

    // Per-lane view of one request: which command slots hit this LED.
    typedef struct packed {
        logic       hit_a;
        logic [2:0] cmd_a;
        logic       hit_b;
        logic [2:0] cmd_b;
    } t_lane_req;

    // One result: the drive of both LEDs.
    typedef struct packed {
        logic [1:0] led0;
        logic [1:0] led1;
    } t_result;

    // Solid commands are off, green and red.
    function automatic logic is_solid(input logic [2:0] cmd);
        is_solid = (cmd == CMD_OFF) || (cmd == CMD_GREEN) || (cmd == CMD_RED);
    endfunction

    function automatic logic [1:0] solid_drive(input logic [2:0] cmd);
        case (cmd)
            CMD_GREEN: solid_drive = DRIVE_GREEN;
            CMD_RED:   solid_drive = DRIVE_RED;
            default:   solid_drive = DRIVE_RELEASED;
        endcase
    endfunction

    function automatic logic is_blink(input logic [2:0] cmd);
        is_blink = (cmd == CMD_GREEN_SLOW) || (cmd == CMD_GREEN_FAST) ||
                   (cmd == CMD_RED_SLOW) || (cmd == CMD_RED_FAST);
    endfunction

    function automatic logic is_slow(input logic [2:0] cmd);
        is_slow = (cmd == CMD_GREEN_SLOW) || (cmd == CMD_RED_SLOW);
    endfunction

    function automatic logic [1:0] blink_colour(input logic [2:0] cmd);
        if ((cmd == CMD_GREEN_SLOW) || (cmd == CMD_GREEN_FAST)) begin
            blink_colour = DRIVE_GREEN;
        end else begin
            blink_colour = DRIVE_RED;
        end
    endfunction

endpackage

// ----- rtl/bslb_lane.sv -----
// One LED lane: applies the commands that hit this LED and runs its blink timer.
// Depends on bslb_pkg.
module bslb_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  bslb_pkg::t_lane_req  i_req,
    input  logic [31:0]          i_now_ms,
    input  logic [15:0]          i_slow_half,
    input  logic [15:0]          i_fast_half,
    output logic [1:0]           o_drive
);
    import bslb_pkg::*;

    logic [2:0]  r_cmd;
    logic        r_phase;
    logic [31:0] r_last;
    logic [1:0]  r_drive;

    logic [2:0]  n_cmd;
    logic        n_phase;
    logic [31:0] n_last;
    logic [1:0]  n_drive;

    logic [15:0] w_half;
    logic [31:0] w_elapsed;

    // Apply both command slots in order, then the blink toggle check.
    always_comb begin
        n_cmd   = r_cmd;
        n_drive = r_drive;
        n_phase = r_phase;
        n_last  = r_last;
        if (i_req.hit_a) begin
            n_cmd = i_req.cmd_a;
            if (is_solid(i_req.cmd_a)) begin
                n_drive = solid_drive(i_req.cmd_a);
            end
        end
        if (i_req.hit_b) begin
            n_cmd = i_req.cmd_b;
            if (is_solid(i_req.cmd_b)) begin
                n_drive = solid_drive(i_req.cmd_b);
            end
        end
        w_half    = is_slow(n_cmd) ? i_slow_half : i_fast_half;
        w_elapsed = i_now_ms - r_last;
        if (is_blink(n_cmd) && (w_elapsed >= {16'd0, w_half})) begin
            n_phase = ~r_phase;
            n_drive = n_phase ? blink_colour(n_cmd) : DRIVE_RELEASED;
            n_last  = i_now_ms;
        end
    end

    // Lane state advances only when a request is accepted.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd   <= CMD_OFF;
            r_phase <= 1'b0;
            r_last  <= 32'd0;
            r_drive <= DRIVE_RELEASED;
        end else if (i_accept) begin
            r_cmd   <= n_cmd;
            r_phase <= n_phase;
            r_last  <= n_last;
            r_drive <= n_drive;
        end
    end

    assign o_drive = n_drive;

endmodule

// ----- rtl/bslb_merge.sv -----
// Merging stage: packs the lane drives into one result and buffers it in a
// two-entry output queue (output register plus skid register). Depends on bslb_pkg.
module bslb_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [1:0]          i_led0,
    input  logic [1:0]          i_led1,
    output logic                o_full,
    output logic                o_valid,
    output bslb_pkg::t_result   o_result,
    input  logic                i_stall
);
    import bslb_pkg::*;

    t_result r_out;
    t_result r_skid;
    logic    r_out_vld;
    logic    r_skid_vld;

    t_result n_out;
    t_result n_skid;
    logic    n_out_vld;
    logic    n_skid_vld;

    t_result w_in;
    logic    w_pop;

    assign w_in.led0 = i_led0;
    assign w_in.led1 = i_led1;
    assign w_pop     = r_out_vld && !i_stall;

    // Pop from the output register first, then place the new result.
    always_comb begin
        n_out      = r_out;
        n_skid     = r_skid;
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        if (w_pop) begin
            if (r_skid_vld) begin
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld = 1'b0;
            end
        end
        if (i_push) begin
            if (!n_out_vld) begin
                n_out     = w_in;
                n_out_vld = 1'b1;
            end else begin
                n_skid     = w_in;
                n_skid_vld = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_full   = r_skid_vld;
    assign o_valid  = r_out_vld;
    assign o_result = r_out;

endmodule

// ----- rtl/bicolor_status_led_blinker_top.sv -----
// Top level of the bicolor status LED blinker: configuration registers,
// pin matching, two LED lanes and the merging output stage. Depends on bslb_pkg.
//
// The block takes one request per clock cycle while not stalled and presents its
// result from the output register; requests and results flow back to back. The
// two LEDs are handled by two lanes side by side, each doing its own command
// update and a 32-bit elapsed-time compare in the accepting cycle. A two-entry
// output queue holds results while the output side stalls, and the input is
// stalled only when both entries are full. Registers sit at byte addresses 0, 4,
// 8 and 12; the user must write them only while idle, which the block does not enforce.
`include "bicolor_status_led_blinker_top_macros.svh"

module bicolor_status_led_blinker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_notify_valid,
    input  logic [7:0]  i_first_pin,
    input  logic [2:0]  i_first_cmd,
    input  logic [7:0]  i_second_pin,
    input  logic [2:0]  i_second_cmd,
    input  logic [31:0] i_now_ms,
    // Result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_led0_drive,
    output logic [1:0]  o_led1_drive
);
    import bslb_pkg::*;

    logic [7:0]  r_first_led_pin;
    logic [7:0]  r_second_led_pin;
    logic [15:0] r_slow_half;
    logic [15:0] r_fast_half;

    logic        w_cfg_wr;
    logic [1:0]  w_reg_idx;
    logic        w_accept;
    logic        w_full;
    logic        w_a_live;
    logic        w_b_live;
    t_lane_req   w_req0;
    t_lane_req   w_req1;
    logic [1:0]  w_drive0;
    logic [1:0]  w_drive1;
    t_result     w_result;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[3:2];

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_led_pin  <= RST_FIRST_LED_PIN;
            r_second_led_pin <= RST_SECOND_LED_PIN;
            r_slow_half      <= RST_SLOW_HALF;
            r_fast_half      <= RST_FAST_HALF;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_FIRST_LED_PIN:  r_first_led_pin  <= pwdata[7:0];
                REG_SECOND_LED_PIN: r_second_led_pin <= pwdata[7:0];
                REG_SLOW_HALF:      r_slow_half      <= pwdata[15:0];
                REG_FAST_HALF:      r_fast_half      <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        case (w_reg_idx)
            REG_FIRST_LED_PIN:  prdata = {24'd0, r_first_led_pin};
            REG_SECOND_LED_PIN: prdata = {24'd0, r_second_led_pin};
            REG_SLOW_HALF:      prdata = {16'd0, r_slow_half};
            REG_FAST_HALF:      prdata = {16'd0, r_fast_half};
            default:            prdata = 32'd0;
        endcase
    end

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    // Pin matching: pin zero is no command, and the first LED wins a shared pin.
    assign w_a_live = i_notify_valid && (i_first_pin != 8'd0);
    assign w_b_live = i_notify_valid && (i_second_pin != 8'd0);

    assign w_req0.hit_a = w_a_live && (i_first_pin == r_first_led_pin);
    assign w_req0.cmd_a = i_first_cmd;
    assign w_req0.hit_b = w_b_live && (i_second_pin == r_first_led_pin);
    assign w_req0.cmd_b = i_second_cmd;

    assign w_req1.hit_a = w_a_live && (i_first_pin != r_first_led_pin) &&
                          (i_first_pin == r_second_led_pin);
    assign w_req1.cmd_a = i_first_cmd;
    assign w_req1.hit_b = w_b_live && (i_second_pin != r_first_led_pin) &&
                          (i_second_pin == r_second_led_pin);
    assign w_req1.cmd_b = i_second_cmd;

    bslb_lane u_lane0 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_req       (w_req0),
        .i_now_ms    (i_now_ms),
        .i_slow_half (r_slow_half),
        .i_fast_half (r_fast_half),
        .o_drive     (w_drive0)
    );

    bslb_lane u_lane1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_req       (w_req1),
        .i_now_ms    (i_now_ms),
        .i_slow_half (r_slow_half),
        .i_fast_half (r_fast_half),
        .o_drive     (w_drive1)
    );

    bslb_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_accept),
        .i_led0   (w_drive0),
        .i_led1   (w_drive1),
        .o_full   (w_full),
        .o_valid  (o_valid),
        .o_result (w_result),
        .i_stall  (i_stall)
    );

    assign o_led0_drive = w_result.led0;
    assign o_led1_drive = w_result.led1;

    // A full queue always has a result on offer.
    `BSLB_ASSERT_NOW(a_full_has_result, o_stall, o_valid, "input stalled with no result queued")
    // Accepting into a held, non-empty queue fills it.
    `BSLB_ASSERT_NEXT(a_fill_on_hold, i_valid && !o_stall && o_valid && i_stall, o_stall, "queue did not fill")
    // A result taken from a queue that was not full leaves room for input.
    `BSLB_ASSERT_NEXT(a_room_after_take, o_valid && !i_stall && !o_stall, !o_stall, "queue full after a take")

endmodule

// ----- verif/tb_bicolor_status_led_blinker_top.sv -----
// Self-checking testbench for the bicolor status LED blinker top level.
// Depends on bslb_pkg and bicolor_status_led_blinker_top; predicts both LED drives per request.
module tb_bicolor_status_led_blinker_top;
    import bslb_pkg::*;

    // The one code that the package leaves unnamed: stored, but neither solid nor blinking.
    localparam logic [2:0] CMD_HOLD = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned HOLD_OFF_AT = 300;
    localparam int unsigned HOLD_OFF_CYCLES = 64;

    typedef struct {
        logic        notify;
        logic [7:0]  pin_a;
        logic [2:0]  cmd_a;
        logic [7:0]  pin_b;
        logic [2:0]  cmd_b;
        logic [31:0] now;
    } t_led_request;

    // Tracks the LED state the block should hold and the drives it still owes.
    class t_drive_scoreboard;
        logic [7:0]  led_pin[2];
        logic [15:0] slow_half;
        logic [15:0] fast_half;
        logic [2:0]  cmd_of[2];
        logic        lit_phase[2];
        logic [31:0] toggled_at[2];
        logic [1:0]  drive[2];
        t_result     predicted_drives[$];
        int unsigned failures;

        function new();
            led_pin[0] = RST_FIRST_LED_PIN;
            led_pin[1] = RST_SECOND_LED_PIN;
            slow_half = RST_SLOW_HALF;
            fast_half = RST_FAST_HALF;
            for (int i = 0; i < 2; i++) begin
                cmd_of[i] = CMD_OFF;
                lit_phase[i] = 1'b0;
                toggled_at[i] = '0;
                drive[i] = DRIVE_RELEASED;
            end
            failures = 0;
        endfunction

        function void write_register(logic [1:0] idx, logic [31:0] value);
            case (idx)
                REG_FIRST_LED_PIN:  led_pin[0] = value[7:0];
                REG_SECOND_LED_PIN: led_pin[1] = value[7:0];
                REG_SLOW_HALF:      slow_half = value[15:0];
                REG_FAST_HALF:      fast_half = value[15:0];
                default: ;
            endcase
        endfunction

        // Pin 0 addresses nothing; the first LED wins when both share a pin.
        function void apply_command(logic [7:0] pin, logic [2:0] cmd);
            int led;
            if (pin == 8'd0) return;
            if (pin == led_pin[0]) led = 0;
            else if (pin == led_pin[1]) led = 1;
            else return;
            cmd_of[led] = cmd;
            case (cmd)
                CMD_OFF:   drive[led] = DRIVE_RELEASED;
                CMD_GREEN: drive[led] = DRIVE_GREEN;
                CMD_RED:   drive[led] = DRIVE_RED;
                default: ;
            endcase
        endfunction

        // A blinking LED toggles once the wrapped elapsed time reaches its half period.
        function void advance_blink(int led, logic [31:0] now);
            logic [1:0]  colour;
            logic [15:0] half;
            logic [31:0] elapsed;
            case (cmd_of[led])
                CMD_GREEN_SLOW: begin colour = DRIVE_GREEN; half = slow_half; end
                CMD_GREEN_FAST: begin colour = DRIVE_GREEN; half = fast_half; end
                CMD_RED_SLOW:   begin colour = DRIVE_RED;   half = slow_half; end
                CMD_RED_FAST:   begin colour = DRIVE_RED;   half = fast_half; end
                default: return;
            endcase
            elapsed = now - toggled_at[led];
            if (elapsed >= {16'd0, half}) begin
                lit_phase[led] = ~lit_phase[led];
                drive[led] = lit_phase[led] ? colour : DRIVE_RELEASED;
                toggled_at[led] = now;
            end
        endfunction

        function void note_request(t_led_request r);
            t_result res;
            if (r.notify) begin
                apply_command(r.pin_a, r.cmd_a);
                apply_command(r.pin_b, r.cmd_b);
            end
            advance_blink(0, r.now);
            advance_blink(1, r.now);
            res.led0 = drive[0];
            res.led1 = drive[1];
            predicted_drives.insert(predicted_drives.size(), res);
        endfunction

        function void check_result(logic [1:0] led0, logic [1:0] led1);
            t_result want;
            if (predicted_drives.size() == 0) begin
                $error("LED drive result with no request waiting: led0 %0d, led1 %0d",
                       led0, led1);
                failures++;
                return;
            end
            want = predicted_drives.pop_front();
            if (led0 !== want.led0) begin
                $error("led0_drive: expected %0d, actual %0d", want.led0, led0);
                failures++;
            end
            if (led1 !== want.led1) begin
                $error("led1_drive: expected %0d, actual %0d", want.led1, led1);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return predicted_drives.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_notify_valid = 1'b0;
    logic [7:0]  i_first_pin = '0;
    logic [2:0]  i_first_cmd = '0;
    logic [7:0]  i_second_pin = '0;
    logic [2:0]  i_second_cmd = '0;
    logic [31:0] i_now_ms = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [1:0]  o_led0_drive;
    logic [1:0]  o_led1_drive;

    t_drive_scoreboard sb = new();
    int unsigned taken_count = 0;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 0;
    logic [31:0] clock_ms = '0;

    bicolor_status_led_blinker_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_notify_valid (i_notify_valid),
        .i_first_pin    (i_first_pin),
        .i_first_cmd    (i_first_cmd),
        .i_second_pin   (i_second_pin),
        .i_second_cmd   (i_second_cmd),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_led0_drive   (o_led0_drive),
        .o_led1_drive   (o_led1_drive)
    );

    always #6 i_clk = ~i_clk;

    // Watch both channels at the clock edge; requests are noted before results are checked.
    always @(posedge i_clk) begin
        t_led_request seen;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                seen.notify = i_notify_valid;
                seen.pin_a = i_first_pin;
                seen.cmd_a = i_first_cmd;
                seen.pin_b = i_second_pin;
                seen.cmd_b = i_second_cmd;
                seen.now = i_now_ms;
                sb.note_request(seen);
                taken_count++;
            end
            if (o_valid && !i_stall) begin
                sb.check_result(o_led0_drive, o_led1_drive);
            end
        end
    end

    // Result side: stall patterns that change every so often, plus one long hold-off.
    initial begin
        int unsigned mode;
        int unsigned mode_left;
        int unsigned hold_left;
        bit          held_off;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        held_off = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held_off && taken_count >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (mode)
                    0: i_stall <= 1'b0;
                    1: i_stall <= ($urandom_range(0, 3) == 0);
                    2: i_stall <= ($urandom_range(0, 3) != 0);
                    default: i_stall <= (mode_left % 2 == 0);
                endcase
            end
        end
    end

    // Global watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("bicolor_status_led_blinker_top: mismatch");
        $finish;
    end

    // Offers one request in bursts with random gaps, then waits for it to be taken.
    task automatic send_request(t_led_request r);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_notify_valid <= r.notify;
        i_first_pin <= r.pin_a;
        i_first_cmd <= r.cmd_a;
        i_second_pin <= r.pin_b;
        i_second_cmd <= r.cmd_b;
        i_now_ms <= r.now;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic send_fields(logic notify, logic [7:0] pin_a, logic [2:0] cmd_a,
                               logic [7:0] pin_b, logic [2:0] cmd_b, logic [31:0] now);
        t_led_request r;
        r.notify = notify;
        r.pin_a = pin_a;
        r.cmd_a = cmd_a;
        r.pin_b = pin_b;
        r.cmd_b = cmd_b;
        r.now = now;
        send_request(r);
    endtask

    // Setup cycle, then access cycle; the register takes the value at the access edge.
    task automatic write_register(logic [1:0] idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_register(idx, value);
    endtask

    // Stop offering and let every owed result come out before touching registers.
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // Pins mostly hit a configured LED so that commands take effect.
    function automatic logic [7:0] pick_pin();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 4) return sb.led_pin[0];
        if (r < 7) return sb.led_pin[1];
        if (r == 7) return 8'd0;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [2:0] pick_cmd();
        if ($urandom_range(0, 19) == 0) return CMD_HOLD;
        return 3'($urandom_range(0, 6));
    endfunction

    // Time mostly moves forward by steps near the half periods, with jumps and rewinds.
    task automatic run_phase(int unsigned count);
        t_led_request r;
        logic [31:0]  span;
        int unsigned  pick;
        pick = $urandom_range(0, 2);
        if (pick == 0) clock_ms = '0;
        else if (pick == 1) clock_ms = 32'hFFFF_FC00;
        else clock_ms = $urandom;
        for (int unsigned k = 0; k < count; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                clock_ms = $urandom;
            end else if (pick < 7) begin
                clock_ms = clock_ms - $urandom_range(1, 1000);
            end else begin
                span = $urandom_range(0, 1) ? {16'd0, sb.slow_half} : {16'd0, sb.fast_half};
                clock_ms = clock_ms + $urandom_range(0, 2 * span + 2);
            end
            r.notify = ($urandom_range(0, 99) < 85);
            r.pin_a = pick_pin();
            r.cmd_a = pick_cmd();
            r.pin_b = pick_pin();
            r.cmd_b = pick_cmd();
            r.now = clock_ms;
            send_request(r);
        end
    endtask

    // Main sequence.
    initial begin
        logic [7:0]  pin0;
        logic [7:0]  pin1;
        logic [15:0] slow;
        logic [15:0] fast;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset settings (pins 1 and 2).
        send_fields(1'b0, 8'd1, CMD_GREEN, 8'd2, CMD_RED, 32'd0);
        send_fields(1'b1, 8'd1, CMD_GREEN, 8'd2, CMD_RED, 32'd0);
        send_fields(1'b1, 8'd1, CMD_OFF, 8'd0, CMD_RED, 32'd5);
        send_fields(1'b1, 8'd3, CMD_GREEN, 8'd255, CMD_RED, 32'd10);
        send_fields(1'b1, 8'd1, CMD_GREEN_SLOW, 8'd2, CMD_RED_FAST, 32'd20);
        send_fields(1'b1, 8'd0, CMD_OFF, 8'd0, CMD_OFF, 32'd120);
        send_fields(1'b0, 8'd1, CMD_OFF, 8'd2, CMD_OFF, 32'd520);
        // The later of two commands for one LED wins.
        send_fields(1'b1, 8'd1, CMD_RED, 8'd1, CMD_GREEN_FAST, 32'd530);
        send_fields(1'b1, 8'd1, CMD_HOLD, 8'd2, CMD_HOLD, 32'd700);
        send_fields(1'b1, 8'd2, CMD_GREEN_FAST, 8'd2, CMD_RED_SLOW, 32'hFFFF_FFFF);
        // Elapsed time across the 32-bit wrap, just short of and then at the half period.
        send_fields(1'b1, 8'd2, CMD_RED_SLOW, 8'd1, CMD_GREEN_SLOW, 32'd498);
        send_fields(1'b0, 8'd0, CMD_OFF, 8'd0, CMD_OFF, 32'd499);
        send_fields(1'b1, 8'd1, CMD_GREEN_FAST, 8'd2, CMD_RED_FAST, 32'h8000_0000);
        send_fields(1'b1, 8'd255, CMD_RED_FAST, 8'd254, CMD_GREEN, 32'h8000_0001);
        send_fields(1'b1, 8'd1, CMD_GREEN_FAST, 8'd2, CMD_GREEN_SLOW, 32'h7FFF_FFFF);
        send_fields(1'b1, 8'd1, CMD_OFF, 8'd2, CMD_OFF, 32'h7FFF_FFFF);

        // Random phases, each under its own register settings.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin pin0 = 8'd255; pin1 = 8'd1; slow = 16'hFFFF; fast = 16'd1; end
                // Both LEDs on one pin, and a zero fast half period.
                1: begin pin0 = 8'd7; pin1 = 8'd7; slow = 16'd3; fast = 16'd0; end
                2: begin pin0 = 8'd1; pin1 = 8'd255; slow = 16'd0; fast = 16'hFFFF; end
                3: begin
                    pin0 = RST_FIRST_LED_PIN;
                    pin1 = RST_SECOND_LED_PIN;
                    slow = RST_SLOW_HALF;
                    fast = RST_FAST_HALF;
                end
                default: begin
                    pin0 = 8'($urandom_range(1, 255));
                    pin1 = 8'($urandom_range(1, 255));
                    slow = 16'($urandom_range(1, 300));
                    fast = 16'($urandom_range(1, 300));
                end
            endcase
            drain();
            write_register(REG_FIRST_LED_PIN, {24'd0, pin0});
            write_register(REG_SECOND_LED_PIN, {24'd0, pin1});
            write_register(REG_SLOW_HALF, {16'd0, slow});
            write_register(REG_FAST_HALF, {16'd0, fast});
            run_phase(167);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("bicolor_status_led_blinker_top: match");
        end else begin
            $display("bicolor_status_led_blinker_top: mismatch");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bslb_pkg.sv
rtl/bslb_lane.sv
rtl/bslb_merge.sv
rtl/bicolor_status_led_blinker_top.sv
verif/tb_bicolor_status_led_blinker_top.sv
